>>> design/form_url_percent_decoder_defines.svh
// ---------------------------------------------------------------------------
// form_url_percent_decoder_defines.svh
// assertion macros for the form url percent decoder
// ---------------------------------------------------------------------------
`ifndef FORM_URL_PERCENT_DECODER_DEFINES_SVH
`define FORM_URL_PERCENT_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// property must hold at every enabled clock edge
`define FUPD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen at an enabled clock edge
`define FUPD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define FUPD_ASSERT(lbl, clk, rst_n, prop, msg)
`define FUPD_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)

`endif

`endif

>>> design/fupd_pkg.sv
// ---------------------------------------------------------------------------
// fupd_pkg
// character codes, decoder phases and hex digit helper
// ---------------------------------------------------------------------------
package fupd_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned PHASE_W = 2;
    localparam int unsigned COUNT_W = 2;

    localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CHAR_PCT   = 8'h25;
    localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;

    localparam logic [BYTE_W-1:0] DIG_LO      = 8'h30;
    localparam logic [BYTE_W-1:0] DIG_HI      = 8'h39;
    localparam logic [BYTE_W-1:0] UPPER_LO    = 8'h41;
    localparam logic [BYTE_W-1:0] UPPER_HI    = 8'h46;
    localparam logic [BYTE_W-1:0] LOWER_LO    = 8'h61;
    localparam logic [BYTE_W-1:0] LOWER_HI    = 8'h66;
    localparam logic [BYTE_W-1:0] UPPER_OFFS  = 8'h37;
    localparam logic [BYTE_W-1:0] LOWER_OFFS  = 8'h57;

    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_PCT  = 2'd1;
    localparam logic [PHASE_W-1:0] PH_DIG  = 2'd2;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_decode(input logic [BYTE_W-1:0] c);
        hex_t               h;
        logic [BYTE_W-1:0]  diff;
        h    = '0;
        diff = '0;
        if (c inside {[DIG_LO:DIG_HI]}) begin
            diff = c - DIG_LO;
            h.ok = 1'b1;
        end else if (c inside {[UPPER_LO:UPPER_HI]}) begin
            diff = c - UPPER_OFFS;
            h.ok = 1'b1;
        end else if (c inside {[LOWER_LO:LOWER_HI]}) begin
            diff = c - LOWER_OFFS;
            h.ok = 1'b1;
        end
        h.val = diff[3:0];
        return h;
    endfunction

endpackage

>>> design/form_url_percent_decoder.sv
// first result byte is presented in the cycle after its input transaction
// throughput: one input byte per cycle while each input gives at most one result and m_tready is high
// a broken escape gives two or three bytes; the result buffer drains one byte
// per cycle while m_tready is high and holds s_tready low until its last byte leaves
// reset (aresetn low, synchronous) empties the result buffer and returns to idle
// ---------------------------------------------------------------------------
// form_url_percent_decoder
// decodes an application/x-www-form-urlencoded byte stream
// ---------------------------------------------------------------------------
`include "form_url_percent_decoder_defines.svh"

module form_url_percent_decoder
    import fupd_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [BYTE_W-1:0] s_tdata,   // [7:0] in_byte
    input  logic              s_tlast,   // stream_end
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] out_byte
    output logic              m_tlast    // run_last
);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [BYTE_W-1:0]  first_digit_reg, first_digit_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [BYTE_W-1:0]  buf0_reg, buf0_next;
    logic [BYTE_W-1:0]  buf1_reg, buf1_next;
    logic [BYTE_W-1:0]  buf2_reg, buf2_next;

    logic [COUNT_W-1:0] res_count;
    logic [BYTE_W-1:0]  res0, res1, res2;
    hex_t               hex_in, hex_first;
    logic               accept, pop;

    assign m_tvalid = (count_reg != '0);
    assign m_tdata  = buf0_reg;
    assign m_tlast  = (count_reg == COUNT_W'(1));
    assign pop      = m_tvalid && m_tready;
    // take a new byte when the buffer is empty or its last byte leaves now
    assign s_tready = (count_reg == '0) || ((count_reg == COUNT_W'(1)) && m_tready);
    assign accept   = s_tvalid && s_tready;

    assign hex_in    = hex_decode(s_tdata);
    assign hex_first = hex_decode(first_digit_reg);

    // decode of the incoming byte against the escape phase
    always_comb begin
        res_count        = '0;
        res0             = s_tdata;
        res1             = s_tdata;
        res2             = s_tdata;
        phase_next       = PH_IDLE;
        first_digit_next = first_digit_reg;
        case (phase_reg)
            PH_PCT: begin
                if (s_tlast) begin
                    res_count = COUNT_W'(2);
                    res0      = CHAR_PCT;
                    res1      = (s_tdata == CHAR_PLUS) ? CHAR_SPACE : s_tdata;
                end else if (hex_in.ok) begin
                    first_digit_next = s_tdata;
                    phase_next       = PH_DIG;
                end else begin
                    res_count = COUNT_W'(2);
                    res0      = CHAR_PCT;
                    res1      = s_tdata;
                end
            end
            PH_DIG: begin
                if (hex_in.ok) begin
                    res_count = COUNT_W'(1);
                    res0      = {hex_first.val, hex_in.val};
                end else begin
                    res_count = COUNT_W'(3);
                    res0      = CHAR_PCT;
                    res1      = first_digit_reg;
                    res2      = s_tdata;
                end
            end
            default: begin
                if (s_tdata == CHAR_PLUS) begin
                    res_count = COUNT_W'(1);
                    res0      = CHAR_SPACE;
                end else if ((s_tdata == CHAR_PCT) && !s_tlast) begin
                    phase_next = PH_PCT;
                end else begin
                    res_count = COUNT_W'(1);
                end
            end
        endcase
    end

    always_comb begin
        count_next = count_reg;
        buf0_next  = buf0_reg;
        buf1_next  = buf1_reg;
        buf2_next  = buf2_reg;
        if (accept) begin
            count_next = res_count;
            buf0_next  = res0;
            buf1_next  = res1;
            buf2_next  = res2;
        end else if (pop) begin
            count_next = count_reg - COUNT_W'(1);
            buf0_next  = buf1_reg;
            buf1_next  = buf2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (accept) begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            first_digit_reg <= first_digit_next;
        end
        buf0_reg <= buf0_next;
        buf1_reg <= buf1_next;
        buf2_reg <= buf2_next;
    end

    `FUPD_ASSERT(a_load_count, aclk, aresetn, accept |=> (count_reg == $past(res_count)), "result count not loaded on accept")
    `FUPD_ASSERT(a_drain_count, aclk, aresetn, (pop && !accept) |=> (count_reg == ($past(count_reg) - COUNT_W'(1))), "buffer count wrong after drain")
    `FUPD_ASSERT(a_end_idle, aclk, aresetn, (accept && s_tlast) |=> (phase_reg == PH_IDLE), "escape held across stream end")
    `FUPD_ASSERT_NEVER(a_digit_hex, aclk, aresetn, (phase_reg == PH_DIG) && !hex_first.ok, "held first digit is not hex")

endmodule

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench
// stream test of the form url percent decoder: a clocked driver feeds encoded
// bytes from a queue, a clocked monitor checks every result transaction
// against a local decoder model, with random gaps and stalls on both sides
// ---------------------------------------------------------------------------
module testbench
    import fupd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RANDOM_ITEMS = 400;
    localparam int unsigned CYCLE_LIMIT  = 300000;
    localparam int unsigned HOLD_AFTER   = 150;
    localparam int unsigned HOLD_CYCLES  = 300;
    localparam int unsigned MAX_SHOWN    = 10;

    typedef struct {
        logic [BYTE_W-1:0] data;
        logic              last;
        int unsigned       gap;
    } enc_byte_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              tlast;
    } dec_byte_t;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [BYTE_W-1:0] s_tdata  = '0;
    logic              s_tlast  = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tlast;

    enc_byte_t   encoded_q[$];
    dec_byte_t   decoded_q[$];

    // decoder model state
    logic [PHASE_W-1:0] dec_phase = PH_IDLE;
    logic [BYTE_W-1:0]  dec_digit = '0;

    enc_byte_t   staged;
    logic        have_staged = 1'b0;
    int unsigned stage_wait  = 0;
    int unsigned fed_count   = 0;
    int unsigned got_count   = 0;
    int unsigned rx_wait     = 0;
    int unsigned rx_draw;
    logic        rx_hold     = 1'b0;
    logic        hold_done   = 1'b0;
    int unsigned hold_left   = 0;
    int unsigned cycles      = 0;
    int unsigned errors      = 0;
    int unsigned gap_mode    = 1;
    int unsigned random_fed  = 0;
    dec_byte_t   want;

    int unsigned n_escapes = 0;
    int unsigned n_broken  = 0;
    int unsigned n_cut     = 0;
    int unsigned n_plus    = 0;
    int unsigned n_ends    = 0;

    form_url_percent_decoder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // {valid, value} of a hex digit character
    function automatic logic [4:0] digit_value(input logic [BYTE_W-1:0] c);
        logic [BYTE_W-1:0] d;
        d = '0;
        if (c >= DIG_LO && c <= DIG_HI) begin
            d = c - DIG_LO;
        end else if (c >= UPPER_LO && c <= UPPER_HI) begin
            d = c - UPPER_OFFS;
        end else if (c >= LOWER_LO && c <= LOWER_HI) begin
            d = c - LOWER_OFFS;
        end else begin
            return 5'b0;
        end
        return {1'b1, d[3:0]};
    endfunction

    // works out the decoded bytes caused by one accepted encoded byte
    function automatic void decode_predict(input logic [BYTE_W-1:0] c, input logic fin);
        logic [BYTE_W-1:0] outs[$];
        logic [4:0]        lo;
        logic [4:0]        hi;
        lo = digit_value(c);
        hi = digit_value(dec_digit);
        if (fin) n_ends++;
        case (dec_phase)
            PH_PCT: begin
                if (fin) begin
                    outs.push_back(CHAR_PCT);
                    outs.push_back(c == CHAR_PLUS ? CHAR_SPACE : c);
                    n_cut++;
                end else if (lo[4]) begin
                    dec_digit = c;
                end else begin
                    outs.push_back(CHAR_PCT);
                    outs.push_back(c);
                    n_broken++;
                end
                dec_phase = (!fin && lo[4]) ? PH_DIG : PH_IDLE;
            end
            PH_DIG: begin
                if (lo[4]) begin
                    outs.push_back({hi[3:0], lo[3:0]});
                    n_escapes++;
                end else begin
                    outs.push_back(CHAR_PCT);
                    outs.push_back(dec_digit);
                    outs.push_back(c);
                    n_broken++;
                end
                dec_phase = PH_IDLE;
            end
            default: begin
                dec_phase = PH_IDLE;
                if (c == CHAR_PLUS) begin
                    outs.push_back(CHAR_SPACE);
                    n_plus++;
                end else if (c == CHAR_PCT && !fin) begin
                    dec_phase = PH_PCT;
                end else begin
                    outs.push_back(c);
                end
            end
        endcase
        foreach (outs[i])
            decoded_q.push_back('{data: outs[i], tlast: (i == outs.size() - 1)});
    endfunction

    function automatic logic [BYTE_W-1:0] pick_digit();
        int unsigned k;
        k = $urandom_range(0, 21);
        if (k < 10) return DIG_LO + BYTE_W'(k);
        if (k < 16) return UPPER_LO + BYTE_W'(k - 10);
        return LOWER_LO + BYTE_W'(k - 16);
    endfunction

    // non-hex byte, half the time right next to a digit range or a plus or percent
    function automatic logic [BYTE_W-1:0] pick_non_digit();
        logic [BYTE_W-1:0] c;
        logic [4:0]        v;
        if ($urandom_range(0, 1) == 0) begin
            case ($urandom_range(0, 7))
                0: c = DIG_LO - 8'd1;
                1: c = DIG_HI + 8'd1;
                2: c = UPPER_LO - 8'd1;
                3: c = UPPER_HI + 8'd1;
                4: c = LOWER_LO - 8'd1;
                5: c = LOWER_HI + 8'd1;
                6: c = CHAR_PLUS;
                default: c = CHAR_PCT;
            endcase
            return c;
        end
        do begin
            c = BYTE_W'($urandom_range(0, 255));
            v = digit_value(c);
        end while (v[4]);
        return c;
    endfunction

    task automatic queue_byte(input logic [BYTE_W-1:0] data, input logic last);
        enc_byte_t   e;
        int unsigned g;
        case (gap_mode)
            0: g = 0;
            1: g = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 18) : 0;
            default: g = $urandom_range(0, 18);
        endcase
        e.data = data;
        e.last = last;
        e.gap  = g;
        encoded_q.push_back(e);
        random_fed++;
    endtask

    // random bytes, well-formed escapes with random content, plus signs, and broken or cut escapes
    task automatic queue_random_run();
        logic        end_here;
        int unsigned kind;
        end_here = ($urandom_range(0, 7) == 0);
        kind     = $urandom_range(0, 99);
        if (kind < 25) begin
            queue_byte(BYTE_W'($urandom_range(0, 255)), end_here);
        end else if (kind < 60) begin
            queue_byte(CHAR_PCT, 1'b0);
            queue_byte(pick_digit(), 1'b0);
            queue_byte(pick_digit(), end_here);
        end else if (kind < 70) begin
            queue_byte(CHAR_PLUS, end_here);
        end else if (kind < 80) begin
            queue_byte(CHAR_PCT, 1'b0);
            queue_byte(pick_non_digit(), end_here);
        end else if (kind < 90) begin
            queue_byte(CHAR_PCT, 1'b0);
            queue_byte(pick_digit(), 1'b0);
            queue_byte(pick_non_digit(), end_here);
        end else if (kind < 95) begin
            queue_byte(CHAR_PCT, 1'b1);
        end else begin
            queue_byte(CHAR_PCT, 1'b0);
            queue_byte(BYTE_W'($urandom_range(0, 255)), 1'b1);
        end
    endtask

    // driver: one encoded byte per transaction, random gap before each
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tlast  <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_predict(s_tdata, s_tlast);
                fed_count <= fed_count + 1;
            end
            if (!(s_tvalid && !s_tready)) begin
                if (!have_staged && encoded_q.size() != 0) begin
                    staged      = encoded_q.pop_front();
                    have_staged = 1'b1;
                    stage_wait  = staged.gap;
                end
                if (have_staged && stage_wait == 0) begin
                    s_tvalid    <= 1'b1;
                    s_tdata     <= staged.data;
                    s_tlast     <= staged.last;
                    have_staged  = 1'b0;
                end else begin
                    s_tvalid <= 1'b0;
                    if (have_staged) stage_wait--;
                end
            end
        end
    end

    // long receiver hold-off so the result buffer fills and the input stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            rx_hold   <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            if (hold_left == 1) rx_hold <= 1'b0;
        end else if (!hold_done && fed_count >= HOLD_AFTER) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rx_hold   <= 1'b1;
        end
    end

    // monitor: checks each result transaction and paces m_tready
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_count++;
                if (decoded_q.size() == 0) begin
                    errors++;
                    if (errors <= MAX_SHOWN)
                        $display("unexpected result: data %h last %b", m_tdata, m_tlast);
                end else begin
                    want = decoded_q.pop_front();
                    if (m_tdata !== want.data || m_tlast !== want.tlast) begin
                        errors++;
                        if (errors <= MAX_SHOWN)
                            $display("result %0d: expected data %h last %b, got data %h last %b",
                                     got_count, want.data, want.tlast, m_tdata, m_tlast);
                    end
                end
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
            end else if (m_tvalid && m_tready) begin
                // calm stretches without stalls every third block of results
                rx_draw = ((got_count / 48) % 3 == 0) ? 0 : $urandom_range(0, 18);
                m_tready <= (rx_draw == 0);
                rx_wait  <= rx_draw;
            end else if (!m_tready) begin
                if (rx_wait <= 1) m_tready <= 1'b1;
                else rx_wait <= rx_wait - 1;
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, decoded_q.size());
            $display("testbench: errors");
            $finish;
        end
    end

    initial begin
        // plain bytes at the extremes, a plus and a stream end on a plain byte
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(CHAR_PLUS, 1'b0);
        queue_byte(8'h61, 1'b1);
        // good escapes, both cases, top and bottom digits
        queue_byte(CHAR_PCT, 1'b0);
        queue_byte(8'h30, 1'b0);
        queue_byte(8'h41, 1'b0);
        queue_byte(CHAR_PCT, 1'b0);
        queue_byte(8'h66, 1'b0);
        queue_byte(8'h46, 1'b0);
        // bad first digit, the plus stays raw
        queue_byte(CHAR_PCT, 1'b0);
        queue_byte(CHAR_PLUS, 1'b0);
        queue_byte(CHAR_PCT, 1'b0);
        queue_byte(8'h67, 1'b0);
        // bad second digit
        queue_byte(CHAR_PCT, 1'b0);
        queue_byte(8'h39, 1'b0);
        queue_byte(8'h47, 1'b0);
        // percent as the final byte
        queue_byte(CHAR_PCT, 1'b1);
        // percent followed by the final byte
        queue_byte(CHAR_PCT, 1'b0);
        queue_byte(CHAR_PLUS, 1'b1);
        queue_byte(CHAR_PCT, 1'b0);
        queue_byte(CHAR_PCT, 1'b1);
        // full escape ending the stream
        queue_byte(CHAR_PCT, 1'b0);
        queue_byte(8'h32, 1'b0);
        queue_byte(8'h42, 1'b1);

        random_fed = 0;
        while (random_fed < RANDOM_ITEMS) begin
            if ($urandom_range(0, 30) == 0) gap_mode = $urandom_range(0, 2);
            queue_random_run();
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        @(posedge aclk);
        while (encoded_q.size() != 0 || have_staged || s_tvalid || decoded_q.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (decoded_q.size() != 0) errors++;

        $display("fed %0d encoded bytes, received %0d decoded bytes, %0d stream ends",
                 fed_count, got_count, n_ends);
        $display("escapes %0d, broken escapes %0d, percents cut by stream end %0d, plus %0d",
                 n_escapes, n_broken, n_cut, n_plus);
        if (errors == 0) begin
            $display("testbench: clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
